FILE: sv/multi_key_press_long_release_scanner_top_defines.svh
// Assertion macros shared by the key scanner RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef MULTI_KEY_PRESS_LONG_RELEASE_SCANNER_TOP_DEFINES_SVH
`define MULTI_KEY_PRESS_LONG_RELEASE_SCANNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clk edge outside reset.
`define MKLRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define MKLRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MKLRS_ASSERT(label, prop, msg)
`define MKLRS_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: sv/mklrs_pkg.sv
// Package for the key scanner: sizes, register indexes, status bit positions, types.
// No dependencies.
`timescale 1ns / 1ps

package mklrs_pkg;

    localparam int KEY_COUNT    = 8;
    localparam int STATUS_W     = 32;
    localparam int NIB_W        = 4;
    localparam int TIMER_W      = 16;
    localparam int BEEP_W       = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [BEEP_W-1:0]  BEEP_TICKS = 6'd50;
    localparam logic [BEEP_W-1:0]  BEEP_HALF  = 6'd25;
    localparam logic [TIMER_W-1:0] TIMER_MAX  = 16'hFFFF;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_DELAY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUZZER_ENABLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASED_LEVEL = 2'd3;

    // Bit positions inside a key's status nibble.
    localparam int BIT_PRESSED  = 0;
    localparam int BIT_LONG     = 1;
    localparam int BIT_RELEASED = 2;

    // Input kinds.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Settings every key lane needs.
    typedef struct packed {
        logic [TIMER_W-1:0] stable_delay;
        logic [TIMER_W-1:0] long_delay;
        logic               released_level;
    } key_cfg_t;

    // Control from the top level to one key lane.
    typedef struct packed {
        logic step_en;
        logic clear_en;
    } key_ctl_t;

    // One result beat.
    typedef struct packed {
        logic [STATUS_W-1:0] key_status;
        logic                buzzer_pin;
        logic                bad_index;
    } result_t;

endpackage

FILE: sv/mklrs_key.sv
// One key lane: press timer and status nibble with press, long and release detection.
// Depends on mklrs_pkg and the assertion macro header.
`timescale 1ns / 1ps

module mklrs_key
    import mklrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  key_ctl_t          ctl,
    input  key_cfg_t          cfg,
    input  logic              level,
    output logic [NIB_W-1:0]  nibble_next,
    output logic              release_evt
);

    `include "multi_key_press_long_release_scanner_top_defines.svh"

    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] timer_next;
    logic [NIB_W-1:0]   nibble_reg;
    logic [NIB_W-1:0]   nib_step;
    logic [TIMER_W-1:0] t_mid;
    logic [TIMER_W:0]   ceiling;

    assign ceiling = {1'b0, cfg.long_delay} + (TIMER_W+1)'(2);

    always_comb
    begin
        nib_step    = nibble_reg;
        t_mid       = timer_reg;
        release_evt = 1'b0;
        timer_next  = timer_reg;
        if (!nibble_reg[BIT_RELEASED])
        begin
            if (level != cfg.released_level)
            begin
                if (!nibble_reg[BIT_PRESSED])
                begin
                    if (timer_reg == '0)
                    begin
                        t_mid = TIMER_W'(1);
                    end
                    if (t_mid > cfg.stable_delay)
                    begin
                        nib_step[BIT_PRESSED] = 1'b1;
                    end
                end
                else if (!nibble_reg[BIT_LONG])
                begin
                    if (timer_reg > cfg.long_delay)
                    begin
                        nib_step[BIT_LONG] = 1'b1;
                    end
                end
            end
            else
            begin
                if (nibble_reg[BIT_PRESSED])
                begin
                    nib_step[BIT_RELEASED] = 1'b1;
                    release_evt            = 1'b1;
                end
                t_mid = '0;
            end
            // advance only below the ceiling, never wrap
            if (t_mid != '0 && {1'b0, t_mid} < ceiling && t_mid != TIMER_MAX)
            begin
                timer_next = t_mid + TIMER_W'(1);
            end
            else
            begin
                timer_next = t_mid;
            end
        end
    end

    always_comb
    begin
        if (ctl.step_en)
        begin
            nibble_next = nib_step;
        end
        else if (ctl.clear_en)
        begin
            nibble_next = '0;
        end
        else
        begin
            nibble_next = nibble_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg  <= '0;
            nibble_reg <= '0;
        end
        else
        begin
            if (ctl.step_en)
            begin
                timer_reg <= timer_next;
            end
            nibble_reg <= nibble_next;
        end
    end

    `MKLRS_ASSERT(a_long_needs_press, nibble_reg[BIT_LONG] |-> nibble_reg[BIT_PRESSED], "long flag without pressed flag")
    `MKLRS_ASSERT(a_release_freezes, (nibble_reg[BIT_RELEASED] && !ctl.clear_en) |=> ($stable(nibble_reg) && $stable(timer_reg)), "released key changed without clear")
    `MKLRS_ASSERT(a_release_needs_press, nibble_reg[BIT_RELEASED] |-> nibble_reg[BIT_PRESSED], "released flag without pressed flag")

endmodule

FILE: sv/multi_key_press_long_release_scanner_top.sv
// Top level of the key scanner: config registers, key lanes, beep timer, output buffer.
// Depends on mklrs_pkg, mklrs_key and the assertion macro header.
`timescale 1ns / 1ps

// Key scanner with press, long-press and release detection and a release beep.
// Each input beat is either a scan tick (kind = 0) carrying the raw pin levels of
// up to KEY_COUNT keys, or a clear request (kind = 1) that wipes one key's status
// nibble. Every beat yields exactly one result beat: the whole 32-bit status word
// (nibble per key: bit 0 pressed, bit 1 long, bit 2 released), the buzzer pin
// (0 = sounding) and bad_index, set when a clear names a key at or above KEY_COUNT.
// All keys are evaluated in parallel by one level of compare and increment logic,
// so a beat is taken every cycle while in_ready is high; each result is registered
// into a two-entry output buffer (output register plus skid register), which keeps
// the input ready for one more beat while a result waits; in_ready drops only when
// both entries are full. Configuration writes (cfg_we, cfg_index, cfg_data) take
// effect at once and are meant for idle periods. A released key stays frozen until
// its nibble is cleared; a release starts a 50-tick beep unless one is running.
module multi_key_press_long_release_scanner_top
    import mklrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [7:0]            pin_levels,
    input  logic [7:0]            key_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   key_status,
    output logic                  buzzer_pin,
    output logic                  bad_index
);

    `include "multi_key_press_long_release_scanner_top_defines.svh"

    // configuration
    logic [TIMER_W-1:0] stable_delay_reg;
    logic [TIMER_W-1:0] long_delay_reg;
    logic               buzzer_enable_reg;
    logic               released_level_reg;
    key_cfg_t           key_cfg;

    // beep
    logic [BEEP_W-1:0]  beep_reg;
    logic [BEEP_W-1:0]  beep_next;
    logic [BEEP_W-1:0]  beep_start;
    logic               buzzer_reg;
    logic               buzzer_next;

    // handshake
    logic               in_accept;
    logic               tick_en;
    logic               clear_req;
    logic               index_ok;
    logic               out_take;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    result_t            out_reg;
    result_t            skid_reg;
    result_t            res;

    // lanes
    logic [NIB_W-1:0]    nib_next [KEY_COUNT];
    logic [KEY_COUNT-1:0] rel_evt;

    assign in_ready  = !skid_valid_reg;
    assign in_accept = in_valid && in_ready;
    assign tick_en   = in_accept && (kind == KIND_TICK);
    assign clear_req = in_accept && (kind == KIND_CLEAR);
    assign index_ok  = key_index < 8'(KEY_COUNT);
    assign out_take  = out_valid_reg && out_ready;

    // Config write decoder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_delay_reg   <= 16'd20;
            long_delay_reg     <= 16'd1000;
            buzzer_enable_reg  <= 1'b0;
            released_level_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STABLE_DELAY:   stable_delay_reg   <= cfg_data;
                REG_LONG_DELAY:     long_delay_reg     <= cfg_data;
                REG_BUZZER_ENABLE:  buzzer_enable_reg  <= cfg_data[0];
                REG_RELEASED_LEVEL: released_level_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign key_cfg.stable_delay   = stable_delay_reg;
    assign key_cfg.long_delay     = long_delay_reg;
    assign key_cfg.released_level = released_level_reg;

    // One lane per key; all lanes step on the same tick.
    for (genvar k = 0; k < KEY_COUNT; k++)
    begin : g_key
        key_ctl_t ctl;

        assign ctl.step_en  = tick_en;
        assign ctl.clear_en = clear_req && (key_index == 8'(k));

        mklrs_key u_key
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .cfg         (key_cfg),
            .level       (pin_levels[k]),
            .nibble_next (nib_next[k]),
            .release_evt (rel_evt[k])
        );
    end

    // Beep: start on any release if idle, then drive the pin for the first half.
    always_comb
    begin
        beep_start  = beep_reg;
        beep_next   = beep_reg;
        buzzer_next = buzzer_reg;
        if (tick_en)
        begin
            if (beep_reg == '0 && rel_evt != '0)
            begin
                beep_start = BEEP_TICKS;
            end
            if (beep_start != '0)
            begin
                if (beep_start > BEEP_HALF)
                begin
                    if (buzzer_enable_reg)
                    begin
                        buzzer_next = 1'b0;
                    end
                end
                else
                begin
                    buzzer_next = 1'b1;
                end
                beep_next = beep_start - BEEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beep_reg   <= '0;
            buzzer_reg <= 1'b1;
        end
        else
        begin
            beep_reg   <= beep_next;
            buzzer_reg <= buzzer_next;
        end
    end

    // Assemble the result beat from the post-step state.
    always_comb
    begin
        res.key_status = '0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            res.key_status[k*NIB_W +: NIB_W] = nib_next[k];
        end
        res.buzzer_pin = buzzer_next;
        res.bad_index  = (kind == KIND_CLEAR) && !index_ok;
    end

    // Output buffer control: hold results in the output register, spill to skid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= in_accept;
            end
            else
            begin
                out_valid_reg  <= in_accept;
            end
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (in_accept)
                begin
                    skid_reg <= res;
                end
            end
            else if (in_accept)
            begin
                out_reg <= res;
            end
        end
        else if (in_accept)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_status = out_reg.key_status;
    assign buzzer_pin = out_reg.buzzer_pin;
    assign bad_index  = out_reg.bad_index;

    `MKLRS_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid entry without output entry")
    `MKLRS_ASSERT(a_beep_bounded, beep_reg <= BEEP_TICKS, "beep counter out of range")
    `MKLRS_ASSERT(a_beep_counts_down, (tick_en && beep_reg != '0) |=> (beep_reg == $past(beep_reg) - BEEP_W'(1)), "running beep did not count down")
    `MKLRS_ASSERT(a_clear_keeps_beep, clear_req |=> ($stable(beep_reg) && $stable(buzzer_reg)), "clear request touched the beep")

endmodule
